// ----- sv/rfsl_pkg.sv -----
// Shared types, constants and decode helpers for the RF front-end SPI configuration loader.
package rfsl_pkg;

	localparam int NUM_WORDS = 10;
	localparam int NUM_CHIPS = 2;
	localparam int WORD_W    = 28;
	localparam int TAG_W     = 4;
	localparam int FRAME_W   = WORD_W + TAG_W;
	localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int BIT_CNT_W = 6;
	localparam int DIV_W     = 32;
	localparam int IDX_W     = 6;
	localparam int DATA_W    = 32;

	localparam logic [BIT_CNT_W-1:0] LAST_BIT = 6'd33;

	// Register word indexes
	localparam logic [IDX_W-1:0] IDX_SCALE = 6'h0A;
	localparam logic [IDX_W-1:0] IDX_LOAD  = 6'h0B;
	localparam logic [IDX_W-1:0] IDX_ANT   = 6'h0F;
	localparam logic [IDX_W-1:0] IDX_BOOT  = 6'h3F;

	// Chip selection codes written to the load register
	localparam logic [DATA_W-1:0] LOAD_CHIP0 = 32'd0;
	localparam logic [DATA_W-1:0] LOAD_CHIP1 = 32'd1;

	localparam logic [1:0] CHIP_MASK = 2'((1 << NUM_CHIPS) - 1);
	localparam logic [1:0] SEL_CHIP0 = 2'b01;
	localparam logic [1:0] SEL_CHIP1 = 2'b10 & CHIP_MASK;

	localparam logic [DIV_W-1:0] DIV_MIN = 32'd2;

	typedef struct packed {
		logic              kind;
		logic [IDX_W-1:0]  reg_index;
		logic [DATA_W-1:0] write_data;
		logic [1:0]        pll_lock;
		logic              ant_status;
		logic              ant_detect;
		logic              sync_clear;
	} in_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              serial_clock;
		logic              serial_data;
		logic              chip_select_n_a;
		logic              chip_select_n_b;
		logic              antenna_enable;
	} out_item_t;

	// Bus write toward the register file
	typedef struct packed {
		logic              en;
		logic              clr;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] data;
	} bus_wr_t;

	// Configuration held by the register file
	typedef struct packed {
		logic [DIV_W-1:0]  divider_ratio;
		logic [DATA_W-1:0] boot_id;
		logic              antenna_enable;
		logic [1:0]        cs_mask;
	} cfg_t;

	// Commands toward the serial engine
	typedef struct packed {
		logic step;
		logic load;
		logic clr;
	} ser_cmd_t;

	// Serial engine status seen by the bus side and the pins
	typedef struct packed {
		logic                 clock_level;
		logic                 shift_msb;
		logic                 frame_active;
		logic                 loading;
		logic [BIT_CNT_W-1:0] bit_count;
	} ser_status_t;

	// Fixed indexes win over word indexes where they overlap
	function automatic logic is_word_idx(input logic [IDX_W-1:0] idx);
		return (idx < IDX_W'(NUM_WORDS)) && (idx != IDX_SCALE) && (idx != IDX_LOAD)
			&& (idx != IDX_ANT);
	endfunction

endpackage

// ----- sv/rfsl_regfile.sv -----
// Bus register file: configuration words with tags, divider, boot ID, antenna and chip mask.
module rfsl_regfile import rfsl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bus_wr_t              wr,
	input  logic [IDX_W-1:0]     rd_idx,
	input  logic [NUM_WORDS-1:0] frame_sel,
	output cfg_t                 cfg,
	output logic [WORD_W-1:0]    rd_word,
	output logic [FRAME_W-1:0]   frame_word
);

	logic [WORD_W-1:0]    word_q [NUM_WORDS];
	logic [NUM_WORDS-1:0] tag_q;
	logic [DIV_W-1:0]     ratio_q;
	logic [DATA_W-1:0]    boot_q;
	logic                 ant_q;
	logic [1:0]           mask_q;
	logic                 wr_word;
	logic [WIDX_W-1:0]    wr_sel;

	assign wr_word = wr.en && is_word_idx(wr.idx);
	assign wr_sel  = wr.idx[WIDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				word_q[i] <= '0;
			end
			tag_q <= '0;
		end else if (wr.clr) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				word_q[i] <= '0;
			end
			tag_q <= '0;
		end else if (wr_word) begin
			word_q[wr_sel] <= wr.data[WORD_W-1:0];
			tag_q[wr_sel]  <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= '0;
			boot_q  <= '0;
			ant_q   <= 1'b0;
			mask_q  <= '0;
		end else begin
			if (wr.en && wr.idx == IDX_BOOT) begin
				boot_q <= wr.data;
			end
			if (wr.clr) begin
				ratio_q <= '0;
				ant_q   <= 1'b0;
				mask_q  <= '0;
			end else if (wr.en) begin
				if (wr.idx == IDX_SCALE) begin
					ratio_q <= (wr.data < DIV_MIN) ? DIV_MIN : wr.data;
				end
				if (wr.idx == IDX_ANT) begin
					ant_q <= wr.data[0];
				end
				if (wr.idx == IDX_LOAD) begin
					if (wr.data == LOAD_CHIP0) begin
						mask_q <= SEL_CHIP0;
					end else if (wr.data == LOAD_CHIP1) begin
						mask_q <= SEL_CHIP1;
					end else begin
						mask_q <= '0;
					end
				end
			end
		end
	end

	always_comb begin
		rd_word = '0;
		if (rd_idx < IDX_W'(NUM_WORDS)) begin
			rd_word = word_q[rd_idx[WIDX_W-1:0]];
		end
	end

	// Select has at most one bit set: gate each entry at its own place and merge
	always_comb begin
		frame_word = '0;
		for (int k = 0; k < NUM_WORDS; k++) begin
			if (frame_sel[k]) begin
				frame_word = frame_word | {word_q[k], {TAG_W{tag_q[k]}} & TAG_W'(k)};
			end
		end
	end

	assign cfg.divider_ratio  = ratio_q;
	assign cfg.boot_id        = boot_q;
	assign cfg.antenna_enable = ant_q;
	assign cfg.cs_mask        = mask_q;

endmodule

// ----- sv/rfsl_serial.sv -----
// Serial word engine: clock divider, bit counter, word sequencer and shift register.
module rfsl_serial import rfsl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ser_cmd_t             cmd,
	input  logic [DIV_W-1:0]     divider_ratio,
	input  logic [FRAME_W-1:0]   frame_word,
	output logic [NUM_WORDS-1:0] frame_sel,
	output ser_status_t          status
);

	logic                 start_q;
	logic                 loading_q;
	logic [DIV_W-1:0]     div_cnt_q;
	logic                 fall_q;
	logic                 rise_q;
	logic                 clk_lvl_q;
	logic [BIT_CNT_W-1:0] bit_cnt_q;
	logic                 frame_act_q;
	logic [NUM_WORDS-1:0] onehot_q;
	logic [FRAME_W-1:0]   shift_q;

	logic                 new_word;
	logic                 mid_frame;
	logic [NUM_WORDS-1:0] onehot_next;
	logic                 load_frame;

	assign new_word    = fall_q && (bit_cnt_q == LAST_BIT);
	assign mid_frame   = (bit_cnt_q != '0) && (bit_cnt_q != LAST_BIT);
	assign onehot_next = onehot_q << 1;
	assign frame_sel   = start_q ? NUM_WORDS'(1) : onehot_next;
	assign load_frame  = start_q || (new_word && (onehot_next != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= 1'b0;
			loading_q   <= 1'b0;
			div_cnt_q   <= '0;
			fall_q      <= 1'b0;
			rise_q      <= 1'b0;
			clk_lvl_q   <= 1'b0;
			bit_cnt_q   <= '0;
			frame_act_q <= 1'b0;
			onehot_q    <= '0;
			shift_q     <= '0;
		end else if (cmd.step) begin
			start_q <= cmd.load && !cmd.clr;

			if (start_q) begin
				loading_q <= 1'b1;
			end else if (new_word && onehot_q == '0) begin
				loading_q <= 1'b0;
			end

			if (loading_q && fall_q) begin
				div_cnt_q <= '0;
			end else if (loading_q) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end else if (cmd.load) begin
				div_cnt_q <= '0;
			end

			fall_q <= (divider_ratio != '0) && (div_cnt_q == divider_ratio);
			rise_q <= (divider_ratio != '0) && (div_cnt_q == (divider_ratio >> 1));

			if (cmd.clr) begin
				clk_lvl_q <= 1'b0;
			end else if (rise_q) begin
				clk_lvl_q <= 1'b1;
			end else if (fall_q) begin
				clk_lvl_q <= 1'b0;
			end

			if (cmd.clr || new_word) begin
				bit_cnt_q <= '0;
			end else if (fall_q) begin
				bit_cnt_q <= bit_cnt_q + 1'b1;
			end else if (cmd.load) begin
				bit_cnt_q <= '0;
			end

			frame_act_q <= !cmd.clr && mid_frame;

			if (start_q) begin
				onehot_q <= NUM_WORDS'(1);
			end else if (new_word) begin
				onehot_q <= onehot_next;
			end

			if (cmd.clr) begin
				shift_q <= '0;
			end else if (load_frame) begin
				shift_q <= frame_word;
			end else if (fall_q && mid_frame) begin
				shift_q <= shift_q << 1;
			end
		end
	end

	assign status.clock_level  = clk_lvl_q;
	assign status.shift_msb    = shift_q[FRAME_W-1];
	assign status.frame_active = frame_act_q;
	assign status.loading      = loading_q;
	assign status.bit_count    = bit_cnt_q;

`ifndef SYNTHESIS
	a_onehot_word: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(onehot_q))
		else $error("word selector holds more than one bit");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_cnt_q <= LAST_BIT)
		else $error("bit counter ran past the last frame bit");

	a_start_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(start_q && cmd.step) |=> (onehot_q == NUM_WORDS'(1) && loading_q))
		else $error("start did not arm the word sequence");
`endif

endmodule

// ----- sv/rf_frontend_spi_config_loader.sv -----
// Top level of the RF front-end SPI configuration loader: handshake, read mux, result register.
//
//  channel | signals                          | item type   | direction
//  --------+----------------------------------+-------------+----------
//  in      | in_valid, in_ready, in_item      | in_item_t   | toward the block
//  out     | out_valid, out_ready, out_item   | out_item_t  | from the block
//
// Each accepted in item is one clock of the loader: it may carry a bus write and
// yields exactly one out item, computed from the state before that clock.
// Each result passes through one register (the result register); one item is taken every cycle while
// out is drained, since in_ready stays high whenever the result register empties.
// Reset (arst_n low) clears all registers but out_item_q at once; there is no clearing pass.
// A stall on out holds the result register and lowers in_ready; the loader state
// then freezes, because it advances only on accepted items.
module rf_frontend_spi_config_loader import rfsl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic                 step;
	bus_wr_t              bus_wr;
	ser_cmd_t             ser_cmd;
	cfg_t                 cfg;
	ser_status_t          ser_st;
	logic [WORD_W-1:0]    rd_word;
	logic [FRAME_W-1:0]   frame_word;
	logic [NUM_WORDS-1:0] frame_sel;
	out_item_t            result;
	logic                 out_valid_q;
	out_item_t            out_item_q;

	// Take a new item whenever the result register is empty or being drained
	assign in_ready = !out_valid_q || out_ready;
	assign step     = in_valid && in_ready;

	assign bus_wr.en   = step && in_item.kind;
	assign bus_wr.clr  = step && in_item.sync_clear;
	assign bus_wr.idx  = in_item.reg_index;
	assign bus_wr.data = in_item.write_data;

	// Clear kills the start pulse but not the counter restart of a load write
	assign ser_cmd.step = step;
	assign ser_cmd.load = step && in_item.kind && (in_item.reg_index == IDX_LOAD);
	assign ser_cmd.clr  = in_item.sync_clear;

	rfsl_regfile u_regfile (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (bus_wr),
		.rd_idx     (in_item.reg_index),
		.frame_sel  (frame_sel),
		.cfg        (cfg),
		.rd_word    (rd_word),
		.frame_word (frame_word)
	);

	rfsl_serial u_serial (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (ser_cmd),
		.divider_ratio (cfg.divider_ratio),
		.frame_word    (frame_word),
		.frame_sel     (frame_sel),
		.status        (ser_st)
	);

	// Read mux and pins, from the state before this item and from this item's status inputs
	always_comb begin
		unique case (in_item.reg_index)
			IDX_SCALE: result.read_data = cfg.divider_ratio;
			IDX_LOAD:  result.read_data = DATA_W'({ser_st.bit_count, 1'b0, ser_st.loading,
				in_item.pll_lock & CHIP_MASK});
			IDX_ANT:   result.read_data = DATA_W'({in_item.ant_status, in_item.ant_detect,
				3'b000, cfg.antenna_enable});
			IDX_BOOT:  result.read_data = cfg.boot_id;
			default:   result.read_data = DATA_W'(rd_word);
		endcase
		result.serial_clock    = ser_st.clock_level;
		result.serial_data     = ser_st.shift_msb;
		result.chip_select_n_a = !(ser_st.frame_active && cfg.cs_mask[0]);
		result.chip_select_n_b = !(ser_st.frame_active && cfg.cs_mask[1]);
		result.antenna_enable  = cfg.antenna_enable;
	end

	// Hold the result until taken; load a new one on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

`ifndef SYNTHESIS
	a_one_chip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.chip_select_n_a || out_item.chip_select_n_b))
		else $error("both chip selects active in one item");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("item accepted while the result register is stalled");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> out_valid)
		else $error("accepted item produced no result");
`endif

endmodule
